// ===== rtl/sd64_pkg.sv =====
// ----------------------------------------------------------------------------
// sd64_pkg
// Shared types and constants for the pipelined signed 64-bit divider.
// ----------------------------------------------------------------------------
package sd64_pkg;

    localparam int FIELD_WIDTH = 64;

    typedef struct packed {
        logic neg;
        logic div_zero;
    } sd64_ctrl_t;

endpackage

// ===== rtl/sd64_cell.sv =====
// ----------------------------------------------------------------------------
// sd64_cell
// One restoring shift-subtract step of the divider array, with its own
// pipeline register and valid/ready handshake toward both neighbors.
// ----------------------------------------------------------------------------
module sd64_cell #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [DATA_WIDTH-1:0]   in_rem,
    input  logic [DATA_WIDTH-1:0]   in_num,
    input  logic [DATA_WIDTH-1:0]   in_den,
    input  sd64_pkg::sd64_ctrl_t    in_ctrl,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [DATA_WIDTH-1:0]   out_rem,
    output logic [DATA_WIDTH-1:0]   out_num,
    output logic [DATA_WIDTH-1:0]   out_den,
    output sd64_pkg::sd64_ctrl_t    out_ctrl
);
    import sd64_pkg::*;

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    sd64_ctrl_t            ctrl_reg;

    logic [DATA_WIDTH-1:0] shifted;
    logic                  q_bit;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] num_next;
    logic                  load;

    // The shifted partial remainder stays below twice the divisor magnitude,
    // which is at most 2^(DATA_WIDTH-1), so it fits in DATA_WIDTH bits.
    always_comb
    begin
        shifted  = {in_rem[DATA_WIDTH-2:0], in_num[DATA_WIDTH-1]};
        q_bit    = (shifted >= in_den);
        rem_next = q_bit ? (shifted - in_den) : shifted;
        num_next = {in_num[DATA_WIDTH-2:0], q_bit};
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            den_reg  <= in_den;
            ctrl_reg <= in_ctrl;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

// ===== rtl/signed_divider_64_unit.sv =====
// ----------------------------------------------------------------------------
// signed_divider_64_unit
// Fully pipelined signed divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_ready) carries one dividend and one
// divisor per beat; the response channel (rsp_valid, rsp_ready) returns one
// quotient per beat, in request order. Only the low DATA_WIDTH bits of each
// operand are used as two's complement values, and the quotient is
// sign-extended to 64 bits. A zero divisor gives a quotient of zero, and the
// most negative dividend over minus one wraps to the most negative value.
// Operand magnitudes are formed in an input register, a row of DATA_WIDTH
// step cells finds one quotient bit per cell, and the output register applies
// the sign. A new beat is taken every cycle unless every stage is full and
// the receiver stalls. Every stage holds its own valid bit; when the receiver
// stalls, the result waits in the output register and the stages behind it
// keep filling until the whole row is full, so empty slots are squeezed out.
// Reset clears all valid bits and the block then accepts at once.
// ----------------------------------------------------------------------------
module signed_divider_64_unit #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic signed [sd64_pkg::FIELD_WIDTH-1:0] dividend,
    input  logic signed [sd64_pkg::FIELD_WIDTH-1:0] divisor,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic signed [sd64_pkg::FIELD_WIDTH-1:0] quotient
);
    import sd64_pkg::*;

    logic                  valid_c [0:DATA_WIDTH];
    logic                  ready_c [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_c   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] num_c   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] den_c   [0:DATA_WIDTH];
    sd64_ctrl_t            ctrl_c  [0:DATA_WIDTH];

    logic                  pre_valid_reg;
    logic [DATA_WIDTH-1:0] pre_num_reg;
    logic [DATA_WIDTH-1:0] pre_den_reg;
    sd64_ctrl_t            pre_ctrl_reg;

    logic [DATA_WIDTH-1:0] a_raw;
    logic [DATA_WIDTH-1:0] b_raw;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;
    sd64_ctrl_t            ctrl_next;

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] q_reg;
    logic [DATA_WIDTH-1:0] q_next;
    logic                  out_ready;

    always_comb
    begin
        a_raw              = dividend[DATA_WIDTH-1:0];
        b_raw              = divisor[DATA_WIDTH-1:0];
        a_mag              = a_raw[DATA_WIDTH-1] ? (~a_raw + 1'b1) : a_raw;
        b_mag              = b_raw[DATA_WIDTH-1] ? (~b_raw + 1'b1) : b_raw;
        ctrl_next.neg      = a_raw[DATA_WIDTH-1] ^ b_raw[DATA_WIDTH-1];
        ctrl_next.div_zero = (b_raw == '0);
    end

    assign req_ready = !pre_valid_reg || ready_c[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            pre_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            pre_num_reg  <= a_mag;
            pre_den_reg  <= b_mag;
            pre_ctrl_reg <= ctrl_next;
        end
    end

    assign valid_c[0] = pre_valid_reg;
    assign rem_c[0]   = '0;
    assign num_c[0]   = pre_num_reg;
    assign den_c[0]   = pre_den_reg;
    assign ctrl_c[0]  = pre_ctrl_reg;

    for (genvar k = 0; k < DATA_WIDTH; k++)
    begin : g_cell
        sd64_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[k]),
            .in_ready  (ready_c[k]),
            .in_rem    (rem_c[k]),
            .in_num    (num_c[k]),
            .in_den    (den_c[k]),
            .in_ctrl   (ctrl_c[k]),
            .out_valid (valid_c[k+1]),
            .out_ready (ready_c[k+1]),
            .out_rem   (rem_c[k+1]),
            .out_num   (num_c[k+1]),
            .out_den   (den_c[k+1]),
            .out_ctrl  (ctrl_c[k+1])
        );
    end

    // The last cell's remainder and divisor are not needed past this point.
    always_comb
    begin
        if (ctrl_c[DATA_WIDTH].div_zero)
        begin
            q_next = '0;
        end
        else if (ctrl_c[DATA_WIDTH].neg)
        begin
            q_next = ~num_c[DATA_WIDTH] + 1'b1;
        end
        else
        begin
            q_next = num_c[DATA_WIDTH];
        end
    end

    assign out_ready          = !out_valid_reg || rsp_ready;
    assign ready_c[DATA_WIDTH] = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= valid_c[DATA_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_c[DATA_WIDTH] && out_ready)
        begin
            q_reg <= q_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign quotient  = FIELD_WIDTH'(signed'(q_reg));

endmodule
